// ===== hw/rtl/repeated_frame_bit_packer_macros.svh =====
// Assertion macros for the repeated frame bit packer.
// Expects clk and arst_n in the scope of each use.
`ifndef REPEATED_FRAME_BIT_PACKER_MACROS_SVH
`define REPEATED_FRAME_BIT_PACKER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define RFBP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RFBP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/rfbp_pkg.sv =====
// Shared types and codes for the repeated frame bit packer.
// No dependencies.
`default_nettype none

package rfbp_pkg;

	localparam int CNT_W   = 16;
	localparam int BYTES_W = 32;
	localparam int REG_W   = 2;

	localparam logic [BYTES_W-1:0] BYTES_MAX = {BYTES_W{1'b1}};

	localparam logic [1:0] REQ_LOAD    = 2'd0;
	localparam logic [1:0] REQ_RESTART = 2'd1;
	localparam logic [1:0] REQ_READ    = 2'd2;

	localparam logic [1:0] PH_FRAME = 2'd0;
	localparam logic [1:0] PH_PAUSE = 2'd1;
	localparam logic [1:0] PH_DONE  = 2'd2;

	localparam logic [REG_W-1:0] REG_FRAME_BITS       = 2'd0;
	localparam logic [REG_W-1:0] REG_PAUSE_LENGTH     = 2'd1;
	localparam logic [REG_W-1:0] REG_REPEAT_COUNT     = 2'd2;
	localparam logic [REG_W-1:0] REG_PAUSE_AFTER_LAST = 2'd3;

	// one stream bit on its way to the packer
	typedef struct packed {
		logic shift;
		logic frame;
	} step_t;

	// status of a finished read
	typedef struct packed {
		logic               rdy;
		logic               counted;
		logic               finished;
		logic               pulse;
		logic [BYTES_W-1:0] bytes;
	} res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rfbp_frame_mem.sv =====
// Single-bit frame store, one write and one registered read port.
// No package dependencies.
`default_nettype none

module rfbp_frame_mem #(
	parameter int DEPTH = 1024,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic              wr_bit,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic                   rd_bit
);

	logic mem_q [DEPTH];
	logic rd_bit_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_bit;
		end
		if (rd_en) begin
			rd_bit_q <= mem_q[rd_addr];
		end
	end

	assign rd_bit = rd_bit_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rfbp_pack.sv =====
// Word shift register: one stream bit per cycle enters at the top while step.shift is set.
// Depends on rfbp_pkg (step_t).
`default_nettype none

module rfbp_pack #(
	parameter int WORD_BITS = 32
) (
	input  wire logic                 clk,
	input  wire rfbp_pkg::step_t      step,
	input  wire logic                 rd_bit,
	output logic [WORD_BITS-1:0]      word
);

	logic [WORD_BITS-1:0] word_q;

	// after WORD_BITS shifts the earliest bit sits in bit 0
	always_ff @(posedge clk) begin
		if (step.shift) begin
			word_q <= {step.frame & rd_bit, word_q[WORD_BITS-1:1]};
		end
	end

	assign word = word_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rfbp_seq.sv =====
// Playback sequencer: config registers, frame/pause/repeat counters, bit step.
// Depends on rfbp_pkg and repeated_frame_bit_packer_macros.svh.
`default_nettype none
`include "repeated_frame_bit_packer_macros.svh"

module rfbp_seq #(
	parameter int MAX_FRAME_BITS = 1024,
	parameter int WORD_BITS = 32,
	parameter int CFG_W = 16,
	localparam int ADDR_W = $clog2(MAX_FRAME_BITS),
	localparam int POS_W = $clog2(MAX_FRAME_BITS + 1)
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [rfbp_pkg::REG_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]           cfg_data,
	input  wire logic                       in_acc,
	input  wire logic [1:0]                 req_type,
	output logic                            busy,
	output logic                            rd_en,
	output logic [ADDR_W-1:0]               rd_addr,
	output rfbp_pkg::step_t                 step_s1,
	input  wire logic                       take,
	output rfbp_pkg::res_t                  res
);

	localparam int BIT_W = $clog2(WORD_BITS);
	localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(WORD_BITS - 1);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BITS);
	localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);
	localparam logic [rfbp_pkg::BYTES_W-1:0] BYTE_ADD = rfbp_pkg::BYTES_W'(WORD_BITS / 8);
	localparam logic [rfbp_pkg::CNT_W-1:0] CNT_MAX = {rfbp_pkg::CNT_W{1'b1}};

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;
	localparam logic [1:0] ST_WAIT  = 2'd3;

	logic [POS_W-1:0]               flen_q;
	logic [rfbp_pkg::CNT_W-1:0]     plen_q;
	logic [rfbp_pkg::CNT_W-1:0]     rcnt_q;
	logic                           pal_q;

	logic [1:0]                     st_q;
	logic [1:0]                     phase_q;
	logic [POS_W-1:0]               pos_q;
	logic [rfbp_pkg::CNT_W-1:0]     pc_q;
	logic [rfbp_pkg::CNT_W-1:0]     reps_q;
	logic [rfbp_pkg::BYTES_W-1:0]   bytes_q;
	logic [BIT_W-1:0]               cnt_q;
	logic                           counted_q;
	logic                           pulse_q;

	logic [POS_W-1:0]               fb_raw;
	logic [POS_W-1:0]               fb_eff;

	logic [1:0]                     stl_ph;
	logic [POS_W-1:0]               stl_pos;
	logic                           stl_pul;

	logic [1:0]                     stp_ph;
	logic [POS_W-1:0]               stp_pos;
	logic [rfbp_pkg::CNT_W-1:0]     stp_pc;
	logic [rfbp_pkg::CNT_W-1:0]     stp_reps;
	logic                           stp_pul;

	logic [rfbp_pkg::BYTES_W-1:0]   bytes_nxt;

	// frame length is clamped when written
	always_comb begin
		fb_raw = cfg_data[POS_W-1:0];
		if (fb_raw == '0) begin
			fb_eff = POS_ONE;
		end else if (fb_raw > POS_MAX) begin
			fb_eff = POS_MAX;
		end else begin
			fb_eff = fb_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flen_q <= POS_ONE;
			plen_q <= '0;
			rcnt_q <= rfbp_pkg::CNT_W'(1);
			pal_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rfbp_pkg::REG_FRAME_BITS:       flen_q <= fb_eff;
				rfbp_pkg::REG_PAUSE_LENGTH:     plen_q <= cfg_data[rfbp_pkg::CNT_W-1:0];
				rfbp_pkg::REG_REPEAT_COUNT:     rcnt_q <= cfg_data[rfbp_pkg::CNT_W-1:0];
				rfbp_pkg::REG_PAUSE_AFTER_LAST: pal_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// close a pause that already ran its length (start of a read)
	always_comb begin
		stl_ph  = phase_q;
		stl_pos = pos_q;
		stl_pul = 1'b0;
		if (phase_q == rfbp_pkg::PH_PAUSE && pc_q >= plen_q) begin
			if (reps_q >= rcnt_q) begin
				stl_ph  = rfbp_pkg::PH_DONE;
				stl_pul = 1'b1;
			end else begin
				stl_ph  = rfbp_pkg::PH_FRAME;
				stl_pos = '0;
			end
		end
	end

	// one stream bit, then pause settle
	always_comb begin
		stp_ph   = phase_q;
		stp_pos  = pos_q;
		stp_pc   = pc_q;
		stp_reps = reps_q;
		stp_pul  = 1'b0;
		if (phase_q == rfbp_pkg::PH_PAUSE) begin
			stp_pc = pc_q + 1'b1;
		end else if (phase_q == rfbp_pkg::PH_FRAME) begin
			stp_pos = pos_q + 1'b1;
			if (stp_pos >= flen_q) begin
				if (reps_q != CNT_MAX) begin
					stp_reps = reps_q + 1'b1;
				end
				if (stp_reps >= rcnt_q && !pal_q) begin
					stp_ph  = rfbp_pkg::PH_DONE;
					stp_pul = 1'b1;
				end else begin
					stp_ph = rfbp_pkg::PH_PAUSE;
					stp_pc = '0;
				end
			end
		end
		if (stp_ph == rfbp_pkg::PH_PAUSE && stp_pc >= plen_q) begin
			if (stp_reps >= rcnt_q) begin
				stp_ph  = rfbp_pkg::PH_DONE;
				stp_pul = 1'b1;
			end else begin
				stp_ph  = rfbp_pkg::PH_FRAME;
				stp_pos = '0;
			end
		end
	end

	assign bytes_nxt = (bytes_q > rfbp_pkg::BYTES_MAX - BYTE_ADD) ? rfbp_pkg::BYTES_MAX
		: bytes_q + BYTE_ADD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			phase_q   <= rfbp_pkg::PH_FRAME;
			pos_q     <= '0;
			pc_q      <= '0;
			reps_q    <= '0;
			bytes_q   <= '0;
			cnt_q     <= '0;
			counted_q <= 1'b0;
			pulse_q   <= 1'b0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (in_acc && req_type == rfbp_pkg::REQ_RESTART) begin
						phase_q <= rfbp_pkg::PH_FRAME;
						pos_q   <= '0;
						pc_q    <= '0;
						reps_q  <= '0;
						bytes_q <= '0;
						pulse_q <= 1'b0;
					end else if (in_acc && req_type == rfbp_pkg::REQ_READ) begin
						counted_q <= phase_q != rfbp_pkg::PH_DONE;
						cnt_q     <= '0;
						st_q      <= ST_RUN;
						if (phase_q != rfbp_pkg::PH_DONE) begin
							phase_q <= stl_ph;
							pos_q   <= stl_pos;
							pulse_q <= stl_pul;
							bytes_q <= bytes_nxt;
						end else begin
							pulse_q <= 1'b0;
						end
					end
				end
				ST_RUN: begin
					if (phase_q != rfbp_pkg::PH_DONE) begin
						phase_q <= stp_ph;
						pos_q   <= stp_pos;
						pc_q    <= stp_pc;
						reps_q  <= stp_reps;
						pulse_q <= pulse_q | stp_pul;
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == BIT_LAST) begin
						st_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					st_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (take) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// frame bit address goes out now, its data meets the registered step in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_s1 <= '0;
		end else begin
			step_s1.shift <= st_q == ST_RUN;
			step_s1.frame <= st_q == ST_RUN && phase_q == rfbp_pkg::PH_FRAME;
		end
	end

	assign rd_en   = st_q == ST_RUN && phase_q == rfbp_pkg::PH_FRAME;
	assign rd_addr = pos_q[ADDR_W-1:0];
	assign busy    = st_q != ST_IDLE;

	assign res.rdy      = st_q == ST_WAIT;
	assign res.counted  = counted_q;
	assign res.finished = phase_q == rfbp_pkg::PH_DONE;
	assign res.pulse    = pulse_q;
	assign res.bytes    = bytes_q;

	`RFBP_ASSERT_NOW(a_frame_addr_in_range, phase_q == rfbp_pkg::PH_FRAME, pos_q < POS_MAX, "frame position past store")
	`RFBP_ASSERT_NEXT(a_run_ends_after_word, st_q == ST_RUN && cnt_q == BIT_LAST, st_q == ST_FLUSH, "bit loop overran word")
	`RFBP_ASSERT_NOW(a_pulse_only_when_done, pulse_q, phase_q == rfbp_pkg::PH_DONE, "completion flag without end of stream")
	`RFBP_ASSERT_NOW(a_uncounted_no_pulse, st_q == ST_WAIT && !counted_q, !pulse_q, "pulse on a read after the end")

endmodule

`default_nettype wire

// ===== hw/rtl/repeated_frame_bit_packer.sv =====
// Top level of the repeated frame bit packer: ports, frame store, output register.
// Depends on rfbp_pkg, rfbp_frame_mem, rfbp_pack and rfbp_seq.
// A frame of bits is loaded one bit per load request into a single-bit store and played
// back repeat_count times (at least once), with pause_length zero bits between plays (and
// after the last one when pause_after_last is set). Each read request returns one
// WORD_BITS-bit word, earliest stream bit in bit 0, zeros past the end of the stream. Load
// and restart requests give no result. A read walks the stream one bit per cycle through
// the frame store's single read port, then passes a flush state and waits with its result
// until the output register takes it; no new request is accepted before that.
`default_nettype none

module repeated_frame_bit_packer #(
	parameter int MAX_FRAME_BITS = 1024,
	parameter int WORD_BITS = 32,
	localparam int ADDR_W = $clog2(MAX_FRAME_BITS),
	localparam int POS_W = $clog2(MAX_FRAME_BITS + 1),
	localparam int CFG_W = (POS_W > rfbp_pkg::CNT_W) ? POS_W : rfbp_pkg::CNT_W
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [rfbp_pkg::REG_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]           cfg_data,
	input  wire logic                       req_valid,
	output logic                            req_stall,
	input  wire logic [1:0]                 req_type,
	input  wire logic [ADDR_W-1:0]          bit_address,
	input  wire logic                       bit_value,
	output logic                            rsp_valid,
	input  wire logic                       rsp_stall,
	output logic [WORD_BITS-1:0]            packed_word,
	output logic                            word_counted,
	output logic                            stream_finished,
	output logic                            completed_pulse,
	output logic [rfbp_pkg::BYTES_W-1:0]    bytes_emitted
);

	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BITS);

	logic                           busy;
	logic                           req_acc;
	logic                           mem_we;
	logic                           rd_en;
	logic [ADDR_W-1:0]              rd_addr;
	logic                           rd_bit;
	rfbp_pkg::step_t                step_s1;
	rfbp_pkg::res_t                 res;
	logic [WORD_BITS-1:0]           word;
	logic                           take;

	logic                           rsp_valid_q;
	logic [WORD_BITS-1:0]           packed_word_q;
	logic                           word_counted_q;
	logic                           stream_finished_q;
	logic                           completed_pulse_q;
	logic [rfbp_pkg::BYTES_W-1:0]   bytes_emitted_q;

	assign req_stall = busy;
	assign req_acc   = req_valid && !req_stall;
	assign mem_we    = req_acc && req_type == rfbp_pkg::REQ_LOAD
		&& POS_W'(bit_address) < POS_MAX;

	rfbp_frame_mem #(
		.DEPTH(MAX_FRAME_BITS)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.wr_addr (bit_address),
		.wr_bit  (bit_value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_bit  (rd_bit)
	);

	rfbp_seq #(
		.MAX_FRAME_BITS (MAX_FRAME_BITS),
		.WORD_BITS      (WORD_BITS),
		.CFG_W          (CFG_W)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_acc    (req_acc),
		.req_type  (req_type),
		.busy      (busy),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.step_s1   (step_s1),
		.take      (take),
		.res       (res)
	);

	rfbp_pack #(
		.WORD_BITS(WORD_BITS)
	) u_pack (
		.clk    (clk),
		.step   (step_s1),
		.rd_bit (rd_bit),
		.word   (word)
	);

	assign take = res.rdy && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			packed_word_q     <= word;
			word_counted_q    <= res.counted;
			stream_finished_q <= res.finished;
			completed_pulse_q <= res.pulse;
			bytes_emitted_q   <= res.bytes;
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign packed_word     = packed_word_q;
	assign word_counted    = word_counted_q;
	assign stream_finished = stream_finished_q;
	assign completed_pulse = completed_pulse_q;
	assign bytes_emitted   = bytes_emitted_q;

endmodule

`default_nettype wire

// ===== sim/tb_repeated_frame_bit_packer.sv =====
// Testbench for repeated_frame_bit_packer: directed and random request streams with a
// bit-level playback predictor checking every returned word field by field.
// Depends on rfbp_pkg and the repeated_frame_bit_packer RTL.
`timescale 1ns / 100ps

module tb_repeated_frame_bit_packer;

	localparam int FRAME_DEPTH = 1024;
	localparam int WORD_W = 32;
	localparam int CFG_DATA_W = 16;
	localparam int ITEM_TARGET = 1900;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              counted;
		logic              finished;
		logic              pulse;
		logic [31:0]       bytes;
	} word_result_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [rfbp_pkg::REG_W-1:0]     cfg_index;
	logic [CFG_DATA_W-1:0]          cfg_data;
	logic                           req_valid;
	logic                           req_stall;
	logic [1:0]                     req_type;
	logic [9:0]                     bit_address;
	logic                           bit_value;
	logic                           rsp_valid;
	logic                           rsp_stall = 1'b0;
	logic [WORD_W-1:0]              packed_word;
	logic                           word_counted;
	logic                           stream_finished;
	logic                           completed_pulse;
	logic [31:0]                    bytes_emitted;

	// playback model state
	bit          frame_mem [FRAME_DEPTH];
	logic [1:0]  play_phase;
	int unsigned play_pos;
	int unsigned pause_cnt;
	int unsigned plays_done;
	logic [31:0] byte_total;
	logic [10:0] reg_frame_bits;
	logic [15:0] reg_pause_length;
	logic [15:0] reg_repeat_count;
	logic        reg_pause_after_last;

	word_result_t expected_words[$];
	int errors;
	int items_sent;
	bit quiet;

	repeated_frame_bit_packer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_type(req_type),
		.bit_address(bit_address),
		.bit_value(bit_value),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.packed_word(packed_word),
		.word_counted(word_counted),
		.stream_finished(stream_finished),
		.completed_pulse(completed_pulse),
		.bytes_emitted(bytes_emitted)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("FAIL repeated_frame_bit_packer");
		$finish;
	end

	always @(negedge clk) begin
		rsp_stall <= quiet ? 1'b0 : ($urandom_range(99) < 33);
	end

	function automatic void restart_stream();
		play_phase = rfbp_pkg::PH_FRAME;
		play_pos = 0;
		pause_cnt = 0;
		plays_done = 0;
		byte_total = '0;
	endfunction

	// closes a pause that has run its length; 1 when the stream completes here
	function automatic bit close_pause();
		if (play_phase == rfbp_pkg::PH_PAUSE && pause_cnt >= reg_pause_length) begin
			if (plays_done >= reg_repeat_count) begin
				play_phase = rfbp_pkg::PH_DONE;
				return 1'b1;
			end
			play_phase = rfbp_pkg::PH_FRAME;
			play_pos = 0;
		end
		return 1'b0;
	endfunction

	function automatic word_result_t predict_read();
		word_result_t r;
		bit pulse;
		int unsigned limit;
		int b;
		r = '0;
		pulse = 1'b0;
		limit = (reg_frame_bits == 0) ? 1 :
			((reg_frame_bits > FRAME_DEPTH) ? FRAME_DEPTH : reg_frame_bits);
		r.counted = (play_phase != rfbp_pkg::PH_DONE);
		if (r.counted) begin
			if (close_pause())
				pulse = 1'b1;
			for (b = 0; b < WORD_W && play_phase != rfbp_pkg::PH_DONE; b++) begin
				if (play_phase == rfbp_pkg::PH_PAUSE) begin
					pause_cnt++;
				end else begin
					r.word[b] = frame_mem[(play_pos >= FRAME_DEPTH) ? FRAME_DEPTH - 1 : play_pos];
					play_pos++;
					if (play_pos >= limit) begin
						if (plays_done < 16'hFFFF)
							plays_done++;
						if (plays_done >= reg_repeat_count && !reg_pause_after_last) begin
							play_phase = rfbp_pkg::PH_DONE;
							pulse = 1'b1;
						end else begin
							play_phase = rfbp_pkg::PH_PAUSE;
							pause_cnt = 0;
						end
					end
				end
				if (close_pause())
					pulse = 1'b1;
			end
			byte_total = (byte_total > 32'hFFFF_FFFF - 4) ? 32'hFFFF_FFFF : byte_total + 4;
		end
		r.finished = (play_phase == rfbp_pkg::PH_DONE);
		r.pulse = pulse;
		r.bytes = byte_total;
		return r;
	endfunction

	always @(posedge clk) begin : check_words
		word_result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_words.size() == 0) begin
				$error("unexpected word %h", packed_word);
				errors++;
			end else begin
				want = expected_words.pop_front();
				if (packed_word !== want.word) begin
					$error("packed_word: expected %h, got %h", want.word, packed_word);
					errors++;
				end
				if (word_counted !== want.counted) begin
					$error("word_counted: expected %b, got %b", want.counted, word_counted);
					errors++;
				end
				if (stream_finished !== want.finished) begin
					$error("stream_finished: expected %b, got %b", want.finished,
						stream_finished);
					errors++;
				end
				if (completed_pulse !== want.pulse) begin
					$error("completed_pulse: expected %b, got %b", want.pulse, completed_pulse);
					errors++;
				end
				if (bytes_emitted !== want.bytes) begin
					$error("bytes_emitted: expected %0d, got %0d", want.bytes, bytes_emitted);
					errors++;
				end
			end
		end
	end

	// called at a falling edge, returns at a falling edge with the request taken
	task automatic send_request(input logic [1:0] kind, input logic [9:0] addr,
		input logic val);
		if (!quiet) begin
			while ($urandom_range(99) < 33) begin
				req_valid <= 1'b0;
				@(negedge clk);
			end
		end
		req_valid <= 1'b1;
		req_type <= kind;
		bit_address <= addr;
		bit_value <= val;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		case (kind)
			rfbp_pkg::REQ_LOAD: frame_mem[addr] = val;
			rfbp_pkg::REQ_RESTART: restart_stream();
			rfbp_pkg::REQ_READ: expected_words.push_back(predict_read());
			default: ;
		endcase
		if (kind != REQ_UNUSED)
			items_sent++;
		@(negedge clk);
	endtask

	task automatic read_word();
		send_request(rfbp_pkg::REQ_READ, 10'($urandom_range(1023)),
			1'($urandom_range(1)));
	endtask

	task automatic restart_playback();
		send_request(rfbp_pkg::REQ_RESTART, 10'($urandom_range(1023)),
			1'($urandom_range(1)));
	endtask

	// holds off new requests until every word is back, then lets the read engine settle
	task automatic wait_all_words();
		req_valid <= 1'b0;
		while (expected_words.size() != 0)
			@(negedge clk);
		repeat (WORD_W + 8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [rfbp_pkg::REG_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			rfbp_pkg::REG_FRAME_BITS: reg_frame_bits = val[10:0];
			rfbp_pkg::REG_PAUSE_LENGTH: reg_pause_length = val;
			rfbp_pkg::REG_REPEAT_COUNT: reg_repeat_count = val;
			rfbp_pkg::REG_PAUSE_AFTER_LAST: reg_pause_after_last = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all_regs(input logic [10:0] fb, input logic [15:0] pl,
		input logic [15:0] rc, input logic pal);
		write_reg(rfbp_pkg::REG_FRAME_BITS, CFG_DATA_W'(fb));
		write_reg(rfbp_pkg::REG_PAUSE_LENGTH, pl);
		write_reg(rfbp_pkg::REG_REPEAT_COUNT, rc);
		write_reg(rfbp_pkg::REG_PAUSE_AFTER_LAST, CFG_DATA_W'(pal));
	endtask

	// mostly short streams, now and then an extreme
	function automatic logic [CFG_DATA_W-1:0] pick_reg_value(
		input logic [rfbp_pkg::REG_W-1:0] idx);
		bit extreme;
		extreme = ($urandom_range(9) == 0);
		case (idx)
			rfbp_pkg::REG_FRAME_BITS:
				if (extreme)
					case ($urandom_range(3))
						0: return 16'd0;
						1: return 16'd1024;
						2: return 16'd2047;
						default: return 16'($urandom_range(2047));
					endcase
				else
					return 16'($urandom_range(64, 1));
			rfbp_pkg::REG_PAUSE_LENGTH:
				if (extreme)
					return $urandom_range(1) ? 16'hFFFF : 16'd0;
				else
					return 16'($urandom_range(40));
			rfbp_pkg::REG_REPEAT_COUNT:
				if (extreme)
					case ($urandom_range(2))
						0: return 16'd0;
						1: return 16'd1;
						default: return 16'hFFFF;
					endcase
				else
					return 16'($urandom_range(6, 1));
			default:
				return 16'($urandom_range(1));
		endcase
	endfunction

	// every frame bit is written before any playback reads it
	task automatic test_frame_fill();
		int a;
		for (a = 0; a < FRAME_DEPTH; a++)
			send_request(rfbp_pkg::REQ_LOAD, 10'(a), 1'($urandom_range(1)));
	endtask

	task automatic test_reset_values();
		read_word();
		read_word();
		send_request(REQ_UNUSED, 10'h3FF, 1'b1);
		restart_playback();
		read_word();
	endtask

	task automatic test_register_extremes();
		// zero frame length and zero repeat count
		wait_all_words();
		write_all_regs(11'd0, 16'd0, 16'd0, 1'b0);
		restart_playback();
		read_word();
		read_word();
		// oversize frame, longest pause and repeat
		wait_all_words();
		write_all_regs(11'h7FF, 16'hFFFF, 16'hFFFF, 1'b1);
		restart_playback();
		repeat (3) read_word();
		// shrink the frame below the current position mid-play
		wait_all_words();
		write_reg(rfbp_pkg::REG_FRAME_BITS, 16'd20);
		read_word();
		wait_all_words();
		write_reg(rfbp_pkg::REG_PAUSE_LENGTH, 16'd3);
		repeat (2) read_word();
		wait_all_words();
		write_reg(rfbp_pkg::REG_REPEAT_COUNT, 16'd1);
		write_reg(rfbp_pkg::REG_PAUSE_AFTER_LAST, 16'd0);
		repeat (2) read_word();
		// zero-length final pause ends on the frame's last bit
		wait_all_words();
		write_all_regs(11'd32, 16'd0, 16'd2, 1'b1);
		restart_playback();
		repeat (3) read_word();
	endtask

	task automatic test_random_playback();
		int phase_no;
		int reads_left;
		int after_end;
		int tail;
		int pick;
		logic [rfbp_pkg::REG_W-1:0] idx;
		phase_no = 0;
		while (items_sent < ITEM_TARGET) begin
			wait_all_words();
			quiet = (phase_no == 3);
			for (int r = 0; r < 4; r++)
				write_reg(rfbp_pkg::REG_W'(r), pick_reg_value(rfbp_pkg::REG_W'(r)));
			restart_playback();
			reads_left = 60;
			after_end = 0;
			tail = $urandom_range(3, 1);
			while (reads_left > 0 && after_end < tail && items_sent < ITEM_TARGET) begin
				pick = $urandom_range(99);
				if (pick < 8) begin
					send_request(rfbp_pkg::REQ_LOAD, 10'($urandom_range(1023)),
						1'($urandom_range(1)));
				end else if (pick < 10) begin
					send_request(REQ_UNUSED, 10'($urandom_range(1023)),
						1'($urandom_range(1)));
				end else if (pick < 11) begin
					restart_playback();
				end else if (pick < 14) begin
					wait_all_words();
					idx = rfbp_pkg::REG_W'($urandom_range(3));
					write_reg(idx, pick_reg_value(idx));
				end else begin
					read_word();
					reads_left--;
					if (play_phase == rfbp_pkg::PH_DONE)
						after_end++;
				end
			end
			phase_no++;
		end
		quiet = 1'b0;
	endtask

	initial begin
		errors = 0;
		items_sent = 0;
		quiet = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_valid = 1'b0;
		req_type = rfbp_pkg::REQ_LOAD;
		bit_address = '0;
		bit_value = 1'b0;
		reg_frame_bits = 11'd1;
		reg_pause_length = 16'd0;
		reg_repeat_count = 16'd1;
		reg_pause_after_last = 1'b0;
		restart_stream();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_frame_fill();
		test_reset_values();
		test_register_extremes();
		test_random_playback();
		wait_all_words();

		if (errors == 0)
			$display("PASS repeated_frame_bit_packer");
		else
			$display("FAIL repeated_frame_bit_packer");
		$finish;
	end

endmodule

// ===== repeated_frame_bit_packer.f =====
+incdir+hw/rtl
hw/rtl/rfbp_pkg.sv
hw/rtl/rfbp_frame_mem.sv
hw/rtl/rfbp_pack.sv
hw/rtl/rfbp_seq.sv
hw/rtl/repeated_frame_bit_packer.sv
sim/tb_repeated_frame_bit_packer.sv
